// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked at every rising edge outside reset.
`define CHA_ASSERT(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define CHA_NEVER(lbl, c, r, cond, msg) \
  lbl: assert property (@(posedge c) disable iff (r) !(cond)) else $error(msg);
`else
`define CHA_ASSERT(lbl, c, r, prop, msg)
`define CHA_NEVER(lbl, c, r, cond, msg)
`endif

`endif

// File: hw/rtl/cha_pkg.sv
// ---------------------------------------------------------------------------
// cha_pkg
// Shared sizes, codes and types of the contact activation block.
// ---------------------------------------------------------------------------
package cha_pkg;

  localparam int NUM_SAMPLES = 1024;
  localparam int PHI_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_WIDTH   = 10;
  localparam int ADDR_W      = $clog2(NUM_SAMPLES);
  localparam int PADDR_W     = 4;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ON_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_OFF_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_HOLD_LEN      = 2'd2;

  // request types
  localparam logic REQ_EVAL  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic signed [PHI_WIDTH-1:0]   on_threshold;
    logic signed [PHI_WIDTH-1:0]   off_threshold;
    logic        [COUNT_WIDTH-1:0] hold_len;
  } cfg_t;

  // Entry is active exactly when age is nonzero.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] hold;
    logic [COUNT_WIDTH-1:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } state_t;

endpackage

// File: hw/rtl/contact_hysteresis_activation_core.sv
// ---------------------------------------------------------------------------
// contact_hysteresis_activation_core
// Per-sample contact activation with hysteresis and a hold time.
// ---------------------------------------------------------------------------
// Each sample's hold counter and age live in one 1024-entry RAM. For an
// evaluate request the accept cycle issues the RAM read; the held request
// then updates the entry, writes it back and loads the output register. No
// new request is accepted while one is held. A waiting result does not
// block the next accept; the update stalls until the output register
// frees. After reset, and after each clear request, a sweep writes zero to
// all 1024 entries, one per cycle; no request is accepted during the sweep
// (the clear result itself is issued at once). APB writes are taken at any
// time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module contact_hysteresis_activation_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cha_pkg::PADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [cha_pkg::IDX_WIDTH-1:0]        sample_index,
  input  logic signed [cha_pkg::PHI_WIDTH-1:0] phi,
  input  logic                                 sample_valid,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cha_pkg::IDX_WIDTH-1:0]        out_index,
  output logic                                 active,
  output logic [cha_pkg::COUNT_WIDTH-1:0]      age,
  output logic [cha_pkg::COUNT_WIDTH-1:0]      hold_left,
  output logic                                 rejected
);

  cha_pkg::cfg_t   cfg;
  cha_pkg::state_t state, state_next;
  logic [cha_pkg::ADDR_W-1:0] sweep_addr, sweep_addr_next;

  logic                                 in_fire;
  logic                                 pend_fire;
  logic                                 pend_valid;
  logic                                 pend_type;
  logic [cha_pkg::IDX_WIDTH-1:0]        pend_index;
  logic signed [cha_pkg::PHI_WIDTH-1:0] pend_phi;
  logic                                 pend_ok;
  logic                                 pend_in_range;

  logic                        ram_we;
  logic [cha_pkg::ADDR_W-1:0]  ram_waddr;
  cha_pkg::entry_t             ram_wdata;
  cha_pkg::entry_t             ram_rdata;
  logic [cha_pkg::ENTRY_W-1:0] ram_rdata_raw;
  cha_pkg::entry_t             upd_entry;
  logic                        upd_rejected;
  logic                        pend_write;

  cha_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready  = (state == cha_pkg::ST_RUN) && !pend_valid;
  assign in_fire   = in_valid && in_ready;
  assign pend_fire = pend_valid && (!out_valid || out_ready);
  assign pend_write = pend_fire && (pend_type == cha_pkg::REQ_EVAL) && pend_in_range;

  // Request held across the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire) begin
      pend_valid <= 1'b1;
    end else if (pend_fire) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_type     <= req_type;
      pend_index    <= sample_index;
      pend_phi      <= phi;
      pend_ok       <= sample_valid;
      pend_in_range <= (32'(sample_index) < cha_pkg::NUM_SAMPLES);
    end
  end

  cha_state_ram #(
    .DEPTH (cha_pkg::NUM_SAMPLES),
    .WIDTH (cha_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (cha_pkg::ADDR_W'(sample_index)),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = cha_pkg::entry_t'(ram_rdata_raw);

  cha_update u_update (
    .cur       (ram_rdata),
    .phi       (pend_phi),
    .sample_ok (pend_ok),
    .cfg       (cfg),
    .nxt       (upd_entry),
    .rejected  (upd_rejected)
  );

  always_comb begin
    if (state == cha_pkg::ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = pend_write;
      ram_waddr = cha_pkg::ADDR_W'(pend_index);
      ram_wdata = upd_entry;
    end
  end

  // Sweep sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cha_pkg::ST_SWEEP;
      sweep_addr <= '0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
    end
  end

  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    case (state)
      cha_pkg::ST_SWEEP: begin
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == cha_pkg::ADDR_W'(cha_pkg::NUM_SAMPLES - 1)) begin
          state_next      = cha_pkg::ST_RUN;
          sweep_addr_next = '0;
        end
      end
      cha_pkg::ST_RUN: begin
        if (pend_fire && (pend_type == cha_pkg::REQ_CLEAR)) begin
          state_next      = cha_pkg::ST_SWEEP;
          sweep_addr_next = '0;
        end
      end
      default: begin
        state_next      = cha_pkg::ST_SWEEP;
        sweep_addr_next = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_fire) begin
      out_index <= pend_index;
      if (pend_write) begin
        active    <= (upd_entry.age != '0);
        age       <= upd_entry.age;
        hold_left <= upd_entry.hold;
        rejected  <= upd_rejected;
      end else begin
        active    <= 1'b0;
        age       <= '0;
        hold_left <= '0;
        rejected  <= 1'b0;
      end
    end
  end

  `CHA_ASSERT(a_accept_pends, clk, rst, in_fire |=> pend_valid, "accepted beat not held")
  `CHA_ASSERT(a_clear_sweeps, clk, rst,
    (pend_fire && pend_type == cha_pkg::REQ_CLEAR) |=>
      (state == cha_pkg::ST_SWEEP && sweep_addr == '0), "clear did not start sweep")
  `CHA_ASSERT(a_ram_write_src, clk, rst,
    ram_we |-> (state == cha_pkg::ST_SWEEP || pend_fire), "stray RAM write")
  `CHA_NEVER(a_active_age, clk, rst, out_valid && active && age == '0,
    "active result with zero age")
  `CHA_NEVER(a_rej_active, clk, rst, out_valid && rejected && active,
    "rejected result marked active")

endmodule

// File: hw/rtl/cha_state_ram.sv
// ---------------------------------------------------------------------------
// cha_state_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cha_state_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/cha_cfg_regs.sv
// ---------------------------------------------------------------------------
// cha_cfg_regs
// APB register file holding the thresholds and the hold length.
// ---------------------------------------------------------------------------
module cha_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cha_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output cha_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        cha_pkg::REG_ON_THRESHOLD:  cfg.on_threshold  <= pwdata;
        cha_pkg::REG_OFF_THRESHOLD: cfg.off_threshold <= pwdata;
        cha_pkg::REG_HOLD_LEN:      cfg.hold_len      <= pwdata[cha_pkg::COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cha_pkg::REG_ON_THRESHOLD:  prdata = cfg.on_threshold;
      cha_pkg::REG_OFF_THRESHOLD: prdata = cfg.off_threshold;
      cha_pkg::REG_HOLD_LEN:      prdata = {16'd0, cfg.hold_len};
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/cha_update.sv
// ---------------------------------------------------------------------------
// cha_update
// Hysteresis decision and counter update for one sample entry.
// ---------------------------------------------------------------------------
module cha_update (
  input  cha_pkg::entry_t                    cur,
  input  logic signed [cha_pkg::PHI_WIDTH-1:0] phi,
  input  logic                               sample_ok,
  input  cha_pkg::cfg_t                      cfg,
  output cha_pkg::entry_t                    nxt,
  output logic                               rejected
);

  logic                               cur_on;
  logic                               new_on;
  logic signed [cha_pkg::PHI_WIDTH-1:0] eff_off;

  always_comb begin
    cur_on  = (cur.age != '0);
    eff_off = (cfg.off_threshold < cfg.on_threshold) ? cfg.on_threshold
                                                     : cfg.off_threshold;
    if (cur_on) begin
      new_on = (phi <= eff_off) || (cur.hold != '0);
    end else begin
      new_on = (phi <= cfg.on_threshold);
    end

    nxt      = '0;
    rejected = 1'b0;
    if (!sample_ok) begin
      rejected = 1'b1;
    end else if (new_on) begin
      if (!cur_on) begin
        nxt.hold = cfg.hold_len;
        nxt.age  = cha_pkg::COUNT_WIDTH'(1);
      end else begin
        nxt.hold = (cur.hold != '0) ? cur.hold - 1'b1 : cur.hold;
        nxt.age  = (cur.age != cha_pkg::COUNT_MAX) ? cur.age + 1'b1 : cur.age;
      end
    end
  end

endmodule

// File: bench/tb_contact_hysteresis_activation_core.sv
// ----------------------------------------------------------------------------
// tb_contact_hysteresis_activation_core
// Self-checking bench for the per-sample contact activation core.
// A short table of directed requests runs first. It is followed by random
// request streams on a few hot sample entries under several threshold and
// hold settings, and by a short run on one entry that a long hold keeps
// active while its distance stays far out. Every result is compared in order
// against its directed expectation or a local model of the activation table.
// ----------------------------------------------------------------------------
module tb_contact_hysteresis_activation_core;

  localparam int WATCHDOG_LIMIT = 8192;
  localparam int SEGMENT_ITEMS  = 150;
  localparam int SOAK_STEPS     = 40;
  localparam logic signed [cha_pkg::PHI_WIDTH-1:0] PHI_MIN = 32'sh8000_0000;
  localparam logic signed [cha_pkg::PHI_WIDTH-1:0] PHI_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [cha_pkg::IDX_WIDTH-1:0]   index;
    logic                            active;
    logic [cha_pkg::COUNT_WIDTH-1:0] age;
    logic [cha_pkg::COUNT_WIDTH-1:0] hold_left;
    logic                            rejected;
  } activation_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                            kind;
    logic [1:0]                           reg_idx;
    logic [31:0]                          value;
    logic                                 req;
    logic [cha_pkg::IDX_WIDTH-1:0]        idx;
    logic signed [cha_pkg::PHI_WIDTH-1:0] phi_val;
    logic                                 ok;
    bit                                   typed;
    activation_t                          want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cha_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic [cha_pkg::IDX_WIDTH-1:0] sample_index;
  logic signed [cha_pkg::PHI_WIDTH-1:0] phi;
  logic sample_valid;
  logic out_valid;
  logic out_ready;
  logic [cha_pkg::IDX_WIDTH-1:0] out_index;
  logic active;
  logic [cha_pkg::COUNT_WIDTH-1:0] age;
  logic [cha_pkg::COUNT_WIDTH-1:0] hold_left;
  logic rejected;

  // local copy of the activation table and the registers
  logic                                 entry_active [cha_pkg::NUM_SAMPLES];
  logic [cha_pkg::COUNT_WIDTH-1:0]      entry_hold   [cha_pkg::NUM_SAMPLES];
  logic [cha_pkg::COUNT_WIDTH-1:0]      entry_age    [cha_pkg::NUM_SAMPLES];
  logic signed [cha_pkg::PHI_WIDTH-1:0] cfg_on;
  logic signed [cha_pkg::PHI_WIDTH-1:0] cfg_off;
  logic [cha_pkg::COUNT_WIDTH-1:0]      cfg_hold;

  activation_t                   pending_status_q[$];
  dir_row_t                      directed_q[$];
  logic [cha_pkg::IDX_WIDTH-1:0] hot_idx[8];

  int tx_idle_pct;
  int rx_idle_pct;
  int errors;
  int n_items;
  int n_results;
  int n_clears;
  int n_rejects;
  int n_active;
  int n_settings;
  int idle_cycles;

  contact_hysteresis_activation_core DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .sample_index (sample_index),
    .phi          (phi),
    .sample_valid (sample_valid),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index    (out_index),
    .active       (active),
    .age          (age),
    .hold_left    (hold_left),
    .rejected     (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void wipe_entry(int i);
    entry_active[i] = 1'b0;
    entry_hold[i]   = '0;
    entry_age[i]    = '0;
  endfunction

  function automatic activation_t predict_activation(logic req,
                                                     logic [cha_pkg::IDX_WIDTH-1:0] idx,
                                                     logic signed [cha_pkg::PHI_WIDTH-1:0] p,
                                                     logic ok);
    activation_t                          r;
    logic signed [cha_pkg::PHI_WIDTH-1:0] eff_off;
    logic                                 was;
    logic                                 stays;
    r = '0;
    r.index = idx;
    if (req == cha_pkg::REQ_CLEAR) begin
      for (int i = 0; i < cha_pkg::NUM_SAMPLES; i++) wipe_entry(i);
    end else if (idx < cha_pkg::NUM_SAMPLES) begin
      if (!ok) begin
        r.rejected = 1'b1;
        wipe_entry(int'(idx));
      end else begin
        eff_off = (cfg_off > cfg_on) ? cfg_off : cfg_on;
        was = entry_active[idx];
        stays = was ? ((p <= eff_off) || (entry_hold[idx] != '0)) : (p <= cfg_on);
        if (!stays) begin
          wipe_entry(int'(idx));
        end else begin
          if (!was) begin
            entry_hold[idx] = cfg_hold;
            entry_age[idx]  = cha_pkg::COUNT_WIDTH'(1);
          end else begin
            if (entry_hold[idx] != '0) entry_hold[idx] = entry_hold[idx] - 1'b1;
            if (entry_age[idx] != cha_pkg::COUNT_MAX) entry_age[idx] = entry_age[idx] + 1'b1;
          end
          entry_active[idx] = 1'b1;
          r.active    = 1'b1;
          r.age       = entry_age[idx];
          r.hold_left = entry_hold[idx];
        end
      end
    end
    return r;
  endfunction

  // receiver stall pattern, redrawn every cycle
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    activation_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      n_results++;
      if (pending_status_q.size() == 0) begin
        $error("result beat with no request outstanding (index %0d)", out_index);
        errors++;
      end else begin
        want = pending_status_q.pop_front();
        check_field("out_index", 32'(want.index), 32'(out_index));
        check_field("active", 32'(want.active), 32'(active));
        check_field("age", 32'(want.age), 32'(age));
        check_field("hold_left", 32'(want.hold_left), 32'(hold_left));
        check_field("rejected", 32'(want.rejected), 32'(rejected));
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("no beat for %0d cycles, %0d results outstanding",
           WATCHDOG_LIMIT, pending_status_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_item(logic req, logic [cha_pkg::IDX_WIDTH-1:0] idx,
                           logic signed [cha_pkg::PHI_WIDTH-1:0] p, logic ok,
                           bit typed, activation_t want);
    activation_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    req_type     = req;
    sample_index = idx;
    phi          = p;
    sample_valid = ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_activation(req, idx, p, ok);
    pending_status_q = {pending_status_q, (typed ? want : pred)};
    n_items++;
    if (req == cha_pkg::REQ_CLEAR) n_clears++;
    else if (!ok) n_rejects++;
    else if (pred.active) n_active++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_status_q.size() != 0) @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
    logic [31:0] mask;
    mask    = (reg_idx == cha_pkg::REG_HOLD_LEN) ? 32'h0000_ffff : 32'hffff_ffff;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_idx)
      cha_pkg::REG_ON_THRESHOLD:  cfg_on   = value;
      cha_pkg::REG_OFF_THRESHOLD: cfg_off  = value;
      cha_pkg::REG_HOLD_LEN:      cfg_hold = value[cha_pkg::COUNT_WIDTH-1:0];
      default: ;
    endcase
    // read back through the same port
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (value & mask)) begin
      $error("register %0d read back: expected %0h, got %0h", reg_idx, value & mask,
             prdata & mask);
      errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_config(int pick);
    logic signed [cha_pkg::PHI_WIDTH-1:0] on_v;
    logic signed [cha_pkg::PHI_WIDTH-1:0] off_v;
    logic [31:0]                          hold_v;
    on_v   = $urandom;
    off_v  = on_v + $urandom_range(2000);
    hold_v = $urandom_range(6);
    case (pick)
      0: begin on_v = '0; off_v = '0; end
      1: begin on_v = PHI_MIN; off_v = PHI_MAX; hold_v = 0; end
      2: begin on_v = PHI_MAX; off_v = PHI_MIN; hold_v = 32'h0000_ffff; end
      4: begin off_v = $urandom; hold_v = $urandom; end
      5: off_v = on_v - $urandom_range(5000);
      default: ;
    endcase
    apb_write(cha_pkg::REG_ON_THRESHOLD, on_v);
    apb_write(cha_pkg::REG_OFF_THRESHOLD, off_v);
    apb_write(cha_pkg::REG_HOLD_LEN, hold_v);
    n_settings++;
  endtask

  // distances clustered around the two thresholds, plus wide and extreme values
  function automatic logic signed [cha_pkg::PHI_WIDTH-1:0] rand_phi();
    logic signed [cha_pkg::PHI_WIDTH-1:0] jitter;
    logic signed [cha_pkg::PHI_WIDTH-1:0] eff_off;
    int mode;
    jitter  = $signed($urandom_range(64)) - 32;
    eff_off = (cfg_off > cfg_on) ? cfg_off : cfg_on;
    mode    = $urandom_range(99);
    if (mode < 35) return cfg_on + jitter;
    if (mode < 65) return eff_off + jitter;
    if (mode < 80) return $urandom;
    if (mode < 90) return $urandom_range(1) ? PHI_MAX : PHI_MIN;
    return cfg_on - $urandom_range(100000);
  endfunction

  task automatic run_phase(int tx_pct, int rx_pct, int first_pick);
    logic                          req;
    logic [cha_pkg::IDX_WIDTH-1:0] idx;
    logic                          ok;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    foreach (hot_idx[h])
      hot_idx[h] = cha_pkg::IDX_WIDTH'($urandom_range(cha_pkg::NUM_SAMPLES - 1));
    for (int seg = 0; seg < 4; seg++) begin
      wait_drained();
      load_config((first_pick + seg < 6) ? first_pick + seg : $urandom_range(5));
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // hold off now and then until the pipe is empty
        if ($urandom_range(99) == 0) wait_drained();
        req = ($urandom_range(99) == 0) ? cha_pkg::REQ_CLEAR : cha_pkg::REQ_EVAL;
        idx = ($urandom_range(99) < 85) ? hot_idx[$urandom_range(7)]
              : cha_pkg::IDX_WIDTH'($urandom_range(cha_pkg::NUM_SAMPLES - 1));
        ok  = ($urandom_range(99) < 92);
        send_item(req, idx, rand_phi(), ok, 1'b0, '0);
      end
    end
  endtask

  function automatic void row_cfg(logic [1:0] reg_idx, logic [31:0] value);
    dir_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.reg_idx = reg_idx;
    r.value   = value;
    directed_q = {directed_q, r};
  endfunction

  function automatic void row_item(logic req, logic [cha_pkg::IDX_WIDTH-1:0] idx,
                                   logic signed [cha_pkg::PHI_WIDTH-1:0] p, logic ok,
                                   int typed, int act, int a, int h, int rej);
    dir_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.req     = req;
    r.idx     = idx;
    r.phi_val = p;
    r.ok      = ok;
    r.typed   = (typed != 0);
    r.want    = '{index: idx, active: 1'(act), age: cha_pkg::COUNT_WIDTH'(a),
                  hold_left: cha_pkg::COUNT_WIDTH'(h), rejected: 1'(rej)};
    directed_q = {directed_q, r};
  endfunction

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    req_type     = cha_pkg::REQ_EVAL;
    sample_index = '0;
    phi          = '0;
    sample_valid = 1'b0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    errors       = 0;
    n_items      = 0;
    n_results    = 0;
    n_clears     = 0;
    n_rejects    = 0;
    n_active     = 0;
    n_settings   = 0;
    cfg_on       = '0;
    cfg_off      = '0;
    cfg_hold     = '0;
    for (int i = 0; i < cha_pkg::NUM_SAMPLES; i++) wipe_entry(i);

    // reset values: both thresholds 0, no hold
    row_item(cha_pkg::REQ_EVAL, 10'd0,    0,       1'b1, 1, 1, 1, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd0,    1,       1'b1, 1, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd1023, PHI_MIN, 1'b1, 1, 1, 1, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd1023, PHI_MIN, 1'b1, 1, 1, 2, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd1023, PHI_MAX, 1'b1, 1, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd5,    0,       1'b0, 1, 0, 0, 0, 1);
    row_item(cha_pkg::REQ_EVAL, 10'd1023, PHI_MAX, 1'b1, 1, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_CLEAR, 10'd77,  PHI_MIN, 1'b0, 1, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd0,    -1,      1'b1, 1, 1, 1, 0, 0);
    // hysteresis band with a short hold
    row_cfg(cha_pkg::REG_ON_THRESHOLD, -100);
    row_cfg(cha_pkg::REG_OFF_THRESHOLD, 1000);
    row_cfg(cha_pkg::REG_HOLD_LEN, 3);
    row_item(cha_pkg::REQ_EVAL, 10'd2, 500,  1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd2, -100, 1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd2, 999,  1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd2, 5000, 1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd2, 5000, 1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd2, 5000, 1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd2, -200, 1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd2, -200, 1'b0, 0, 0, 0, 0, 0);
    // off below on: the on threshold governs both ways
    row_cfg(cha_pkg::REG_OFF_THRESHOLD, -5000);
    row_cfg(cha_pkg::REG_HOLD_LEN, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd3, -100, 1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd3, -99,  1'b1, 0, 0, 0, 0, 0);
    row_cfg(cha_pkg::REG_HOLD_LEN, 32'h0000_ffff);
    row_item(cha_pkg::REQ_EVAL, 10'd4, PHI_MIN, 1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd4, PHI_MAX, 1'b1, 0, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_CLEAR, 10'd1023, PHI_MAX, 1'b1, 1, 0, 0, 0, 0);
    row_item(cha_pkg::REQ_EVAL, 10'd4, PHI_MAX, 1'b1, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    tx_idle_pct = 12;
    rx_idle_pct = 60;
    foreach (directed_q[r]) begin
      if (directed_q[r].kind == ROW_CFG) begin
        wait_drained();
        apb_write(directed_q[r].reg_idx, directed_q[r].value);
      end else begin
        send_item(directed_q[r].req, directed_q[r].idx, directed_q[r].phi_val,
                  directed_q[r].ok, directed_q[r].typed, directed_q[r].want);
      end
    end

    run_phase(12, 60, 0);
    run_phase(60, 12, 4);
    run_phase(0, 0, 8);

    // keep one entry active on its hold alone while the distance stays far out
    wait_drained();
    apb_write(cha_pkg::REG_ON_THRESHOLD, 0);
    apb_write(cha_pkg::REG_OFF_THRESHOLD, 0);
    apb_write(cha_pkg::REG_HOLD_LEN, 32'h0000_ffff);
    send_item(cha_pkg::REQ_EVAL, 10'd9, 0, 1'b0, 1'b0, '0);
    send_item(cha_pkg::REQ_EVAL, 10'd9, -1, 1'b1, 1'b0, '0);
    for (int n = 0; n < SOAK_STEPS; n++)
      send_item(cha_pkg::REQ_EVAL, 10'd9, $urandom_range(32'h7fff_ffff, 1), 1'b1, 1'b0, '0);

    wait_drained();
    repeat (16) @(posedge clk);

    $display("Covered %0d requests (%0d clears, %0d invalid samples, %0d active results)",
             n_items, n_clears, n_rejects, n_active);
    $display("over %0d register settings; %0d results checked", n_settings, n_results);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
